// ===== hdl/rfalu_pkg.sv =====
// Shared constants, opcode codes, types and helpers for the R-type ALU with register file.
package rfalu_pkg;

   localparam int NUM_REGS    = 32;
   localparam int DATA_WIDTH  = 32;
   localparam int ADDR_W      = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int IDX_W       = 5;
   localparam int OPC_W       = 4;
   localparam int OUT_W       = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [OPC_W-1:0] OPC_ADD   = 4'd0;
   localparam logic [OPC_W-1:0] OPC_SUB   = 4'd1;
   localparam logic [OPC_W-1:0] OPC_AND   = 4'd2;
   localparam logic [OPC_W-1:0] OPC_OR    = 4'd3;
   localparam logic [OPC_W-1:0] OPC_XOR   = 4'd4;
   localparam logic [OPC_W-1:0] OPC_NOR   = 4'd5;
   localparam logic [OPC_W-1:0] OPC_NAND  = 4'd6;
   localparam logic [OPC_W-1:0] OPC_SLT   = 4'd7;
   localparam logic [OPC_W-1:0] OPC_SLL   = 4'd8;
   localparam logic [OPC_W-1:0] OPC_SRL   = 4'd9;
   localparam logic [OPC_W-1:0] OPC_SRA   = 4'd10;
   localparam logic [OPC_W-1:0] OPC_JR    = 4'd11;
   localparam logic [OPC_W-1:0] OPC_WRITE = 4'd12;

   typedef enum logic [3:0] {
      FN_ADD, FN_SUB, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_NAND,
      FN_SLT, FN_SLL, FN_SRL, FN_SRA, FN_JR, FN_WRITE, FN_NOP
   } fn_type;

   typedef logic [DATA_WIDTH-1:0] word_type;

   typedef struct packed {
      fn_type             fn;
      logic               wr;
      logic               a_ok;
      logic               b_ok;
      logic [IDX_W-1:0]   src_a;
      logic [IDX_W-1:0]   src_b;
      logic [IDX_W-1:0]   dest;
      logic [IDX_W-1:0]   shamt;
      logic [OUT_W-1:0]   load;
   } uop_type;

   function automatic logic in_range(input logic [IDX_W-1:0] idx);
      return int'(idx) < NUM_REGS;
   endfunction

endpackage

// ===== hdl/rtype_alu_with_register_file.sv =====
// An accepted request beat moves from a queue slot to the execute register and then to
// the response register; a response stall can hold it at each of them.
// Throughput: one instruction per cycle while rsp_ready holds; one register file write
// and two registered reads a cycle, and the retiring write is bypassed to the next read.
// A 4-entry micro-op queue parts request acceptance from execution and response stalls.
// Synchronous reset empties the queue and pipeline and marks every register unwritten,
// so all registers read zero right after reset; no clearing pass is needed.
module rtype_alu_with_register_file (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rfalu_pkg::OPC_W-1:0]    req_opcode,
   input  logic [rfalu_pkg::IDX_W-1:0]    req_src_a_index,
   input  logic [rfalu_pkg::IDX_W-1:0]    req_src_b_index,
   input  logic [rfalu_pkg::IDX_W-1:0]    req_dest_index,
   input  logic [rfalu_pkg::IDX_W-1:0]    req_shift_amount,
   input  logic [rfalu_pkg::OUT_W-1:0]    req_load_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_write_enable,
   output logic [rfalu_pkg::IDX_W-1:0]    rsp_write_index,
   output logic [rfalu_pkg::OUT_W-1:0]    rsp_write_value,
   output logic                           rsp_overflow,
   output logic                           rsp_jump_taken,
   output logic [rfalu_pkg::OUT_W-1:0]    rsp_jump_target
);

   logic               dec_valid, dec_ready;
   rfalu_pkg::uop_type dec_uop;
   logic               iss_valid, iss_ready;
   rfalu_pkg::uop_type iss_uop;

   rfalu_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_src_a_index  (req_src_a_index),
      .req_src_b_index  (req_src_b_index),
      .req_dest_index   (req_dest_index),
      .req_shift_amount (req_shift_amount),
      .req_load_value   (req_load_value),
      .uop_valid        (dec_valid),
      .uop_ready        (dec_ready),
      .uop              (dec_uop)
   );

   rfalu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (dec_valid),
      .push_ready (dec_ready),
      .push_uop   (dec_uop),
      .pop_valid  (iss_valid),
      .pop_ready  (iss_ready),
      .pop_uop    (iss_uop)
   );

   rfalu_back u_back (
      .clock            (clock),
      .reset            (reset),
      .issue_valid      (iss_valid),
      .issue_ready      (iss_ready),
      .issue_uop        (iss_uop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_write_enable (rsp_write_enable),
      .rsp_write_index  (rsp_write_index),
      .rsp_write_value  (rsp_write_value),
      .rsp_overflow     (rsp_overflow),
      .rsp_jump_taken   (rsp_jump_taken),
      .rsp_jump_target  (rsp_jump_target)
   );

endmodule

// ===== hdl/rfalu_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
module rfalu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // Read returns the old word when the same address is written in that cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== hdl/rfalu_front.sv =====
// Front end: takes request beats and decodes them into micro-ops for the queue.
module rfalu_front (
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rfalu_pkg::OPC_W-1:0]    req_opcode,
   input  logic [rfalu_pkg::IDX_W-1:0]    req_src_a_index,
   input  logic [rfalu_pkg::IDX_W-1:0]    req_src_b_index,
   input  logic [rfalu_pkg::IDX_W-1:0]    req_dest_index,
   input  logic [rfalu_pkg::IDX_W-1:0]    req_shift_amount,
   input  logic [rfalu_pkg::OUT_W-1:0]    req_load_value,
   output logic                           uop_valid,
   input  logic                           uop_ready,
   output rfalu_pkg::uop_type             uop
);

   rfalu_pkg::fn_type fn;

   always_comb begin
      unique case (req_opcode)
         rfalu_pkg::OPC_ADD:   fn = rfalu_pkg::FN_ADD;
         rfalu_pkg::OPC_SUB:   fn = rfalu_pkg::FN_SUB;
         rfalu_pkg::OPC_AND:   fn = rfalu_pkg::FN_AND;
         rfalu_pkg::OPC_OR:    fn = rfalu_pkg::FN_OR;
         rfalu_pkg::OPC_XOR:   fn = rfalu_pkg::FN_XOR;
         rfalu_pkg::OPC_NOR:   fn = rfalu_pkg::FN_NOR;
         rfalu_pkg::OPC_NAND:  fn = rfalu_pkg::FN_NAND;
         rfalu_pkg::OPC_SLT:   fn = rfalu_pkg::FN_SLT;
         rfalu_pkg::OPC_SLL:   fn = rfalu_pkg::FN_SLL;
         rfalu_pkg::OPC_SRL:   fn = rfalu_pkg::FN_SRL;
         rfalu_pkg::OPC_SRA:   fn = rfalu_pkg::FN_SRA;
         rfalu_pkg::OPC_JR:    fn = rfalu_pkg::FN_JR;
         rfalu_pkg::OPC_WRITE: fn = rfalu_pkg::FN_WRITE;
         default:              fn = rfalu_pkg::FN_NOP;
      endcase
   end

   always_comb begin
      uop.fn    = fn;
      // Drop the write for jr, unused codes and destinations past the file.
      uop.wr    = (fn != rfalu_pkg::FN_JR) && (fn != rfalu_pkg::FN_NOP) &&
                  rfalu_pkg::in_range(req_dest_index);
      uop.a_ok  = rfalu_pkg::in_range(req_src_a_index);
      uop.b_ok  = rfalu_pkg::in_range(req_src_b_index);
      uop.src_a = req_src_a_index;
      uop.src_b = req_src_b_index;
      uop.dest  = req_dest_index;
      uop.shamt = req_shift_amount;
      uop.load  = req_load_value;
   end

   assign uop_valid = req_valid;
   assign req_ready = uop_ready;

endmodule

// ===== hdl/rfalu_queue.sv =====
// Short FIFO of decoded micro-ops between the front end and the execute back end.
module rfalu_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  rfalu_pkg::uop_type push_uop,
   output logic               pop_valid,
   input  logic               pop_ready,
   output rfalu_pkg::uop_type pop_uop
);

   rfalu_pkg::uop_type                 slot_ff [rfalu_pkg::QUEUE_DEPTH];
   logic [rfalu_pkg::QPTR_W-1:0]       wptr_ff, wptr_in;
   logic [rfalu_pkg::QPTR_W-1:0]       rptr_ff, rptr_in;
   logic [rfalu_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                               push_fire;
   logic                               pop_fire;

   assign push_ready = count_ff != rfalu_pkg::QCNT_W'(rfalu_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_uop    = slot_ff[rptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push_fire) begin
         wptr_in = wptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rptr_in = rptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wptr_ff] <= push_uop;
      end
   end

endmodule

// ===== hdl/rfalu_back.sv =====
// Back end: register file read, ALU execute with write-back bypass, and result register.
module rfalu_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           issue_valid,
   output logic                           issue_ready,
   input  rfalu_pkg::uop_type             issue_uop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_write_enable,
   output logic [rfalu_pkg::IDX_W-1:0]    rsp_write_index,
   output logic [rfalu_pkg::OUT_W-1:0]    rsp_write_value,
   output logic                           rsp_overflow,
   output logic                           rsp_jump_taken,
   output logic [rfalu_pkg::OUT_W-1:0]    rsp_jump_target
);

   localparam int DW = rfalu_pkg::DATA_WIDTH;

   logic                              ex_valid_ff, ex_valid_in;
   rfalu_pkg::uop_type                ex_uop_ff;
   logic [rfalu_pkg::NUM_REGS-1:0]    reg_valid_ff, reg_valid_in;
   logic                              a_init_ff, b_init_ff;
   logic                              byp_valid_ff, byp_valid_in;
   logic [rfalu_pkg::IDX_W-1:0]       byp_idx_ff;
   rfalu_pkg::word_type               byp_data_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_we_ff;
   logic [rfalu_pkg::IDX_W-1:0]       rsp_idx_ff;
   logic [rfalu_pkg::OUT_W-1:0]       rsp_val_ff;
   logic                              rsp_ovf_ff;
   logic                              rsp_jmp_ff;
   logic [rfalu_pkg::OUT_W-1:0]       rsp_tgt_ff;

   logic                              issue_fire;
   logic                              ex_fire;
   logic                              ex_we;
   logic [rfalu_pkg::ADDR_W-1:0]      wr_addr;
   logic [rfalu_pkg::ADDR_W-1:0]      rd_addr_a;
   logic [rfalu_pkg::ADDR_W-1:0]      rd_addr_b;
   rfalu_pkg::word_type               ram_a, ram_b;
   rfalu_pkg::word_type               opa, opb;
   rfalu_pkg::word_type               sum, diff, result;
   logic                              ovf;

   assign ex_fire     = ex_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign issue_ready = !ex_valid_ff || ex_fire;
   assign issue_fire  = issue_valid && issue_ready;
   assign ex_we       = ex_fire && ex_uop_ff.wr;
   assign wr_addr     = rfalu_pkg::ADDR_W'(ex_uop_ff.dest);
   assign rd_addr_a   = rfalu_pkg::ADDR_W'(issue_uop.src_a);
   assign rd_addr_b   = rfalu_pkg::ADDR_W'(issue_uop.src_b);

   rfalu_ram #(
      .WIDTH (DW),
      .DEPTH (rfalu_pkg::NUM_REGS)
   ) u_regfile (
      .clock     (clock),
      .wr_en     (ex_we),
      .wr_addr   (wr_addr),
      .wr_data   (result),
      .rd_en     (issue_fire),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (ram_a),
      .rd_data_b (ram_b)
   );

   // The read in the issue cycle misses the write retiring on the same edge: bypass it.
   always_comb begin
      if (!ex_uop_ff.a_ok) begin
         opa = '0;
      end else if (byp_valid_ff && (byp_idx_ff == ex_uop_ff.src_a)) begin
         opa = byp_data_ff;
      end else if (a_init_ff) begin
         opa = ram_a;
      end else begin
         opa = '0;
      end
      if (!ex_uop_ff.b_ok) begin
         opb = '0;
      end else if (byp_valid_ff && (byp_idx_ff == ex_uop_ff.src_b)) begin
         opb = byp_data_ff;
      end else if (b_init_ff) begin
         opb = ram_b;
      end else begin
         opb = '0;
      end
   end

   assign sum  = opa + opb;
   assign diff = opa - opb;

   always_comb begin
      result = '0;
      ovf    = 1'b0;
      case (ex_uop_ff.fn)
         rfalu_pkg::FN_ADD: begin
            result = sum;
            ovf    = (opa[DW-1] ^ sum[DW-1]) & (opb[DW-1] ^ sum[DW-1]);
         end
         rfalu_pkg::FN_SUB: begin
            result = diff;
            ovf    = (opa[DW-1] ^ opb[DW-1]) & (opa[DW-1] ^ diff[DW-1]);
         end
         rfalu_pkg::FN_AND:   result = opa & opb;
         rfalu_pkg::FN_OR:    result = opa | opb;
         rfalu_pkg::FN_XOR:   result = opa ^ opb;
         rfalu_pkg::FN_NOR:   result = ~(opa | opb);
         rfalu_pkg::FN_NAND:  result = ~(opa & opb);
         rfalu_pkg::FN_SLT:   result = DW'($signed(opa) < $signed(opb));
         rfalu_pkg::FN_SLL:   result = opb << ex_uop_ff.shamt;
         rfalu_pkg::FN_SRL:   result = opb >> ex_uop_ff.shamt;
         rfalu_pkg::FN_SRA:   result = $signed(opb) >>> ex_uop_ff.shamt;
         rfalu_pkg::FN_WRITE: result = DW'(ex_uop_ff.load);
         default:             result = '0;
      endcase
   end

   always_comb begin
      ex_valid_in  = ex_valid_ff;
      reg_valid_in = reg_valid_ff;
      byp_valid_in = byp_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ex_fire) begin
         ex_valid_in  = 1'b0;
         rsp_valid_in = 1'b1;
      end
      if (issue_fire) begin
         ex_valid_in = 1'b1;
      end
      if (ex_we) begin
         reg_valid_in[wr_addr] = 1'b1;
         byp_valid_in          = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         reg_valid_ff <= '0;
         byp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ex_valid_ff  <= ex_valid_in;
         reg_valid_ff <= reg_valid_in;
         byp_valid_ff <= byp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue_fire) begin
         ex_uop_ff <= issue_uop;
         a_init_ff <= issue_uop.a_ok && reg_valid_ff[rd_addr_a];
         b_init_ff <= issue_uop.b_ok && reg_valid_ff[rd_addr_b];
      end
      if (ex_we) begin
         byp_idx_ff  <= ex_uop_ff.dest;
         byp_data_ff <= result;
      end
      if (ex_fire) begin
         rsp_we_ff  <= ex_uop_ff.wr;
         rsp_idx_ff <= ex_uop_ff.wr ? ex_uop_ff.dest : '0;
         rsp_val_ff <= ex_uop_ff.wr ? rfalu_pkg::OUT_W'(result) : '0;
         rsp_ovf_ff <= ovf;
         rsp_jmp_ff <= ex_uop_ff.fn == rfalu_pkg::FN_JR;
         rsp_tgt_ff <= (ex_uop_ff.fn == rfalu_pkg::FN_JR) ? rfalu_pkg::OUT_W'(opa) : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_enable = rsp_we_ff;
   assign rsp_write_index  = rsp_idx_ff;
   assign rsp_write_value  = rsp_val_ff;
   assign rsp_overflow     = rsp_ovf_ff;
   assign rsp_jump_taken   = rsp_jmp_ff;
   assign rsp_jump_target  = rsp_tgt_ff;

endmodule

// ===== hdl/rfalu_checker.sv =====
// Port-level checker for the R-type ALU with register file, bound to the top level.
module rfalu_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_ready,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_write_enable,
   input  logic [rfalu_pkg::IDX_W-1:0]    rsp_write_index,
   input  logic [rfalu_pkg::OUT_W-1:0]    rsp_write_value,
   input  logic                           rsp_overflow,
   input  logic                           rsp_jump_taken,
   input  logic [rfalu_pkg::OUT_W-1:0]    rsp_jump_target
);

   // Pipeline drains on reset: no response beat right after, and the queue takes requests.
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("response valid or request stalled right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_write_value) &&
         $stable(rsp_write_index) && $stable(rsp_jump_target))
      else $error("stalled response beat changed");

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |-> rsp_write_index == '0 && rsp_write_value == '0)
      else $error("write fields not zero without a write");

   a_jump_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_jump_taken |-> !rsp_write_enable && !rsp_overflow)
      else $error("jump beat also writes or overflows");

   a_no_jump_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_jump_taken |-> rsp_jump_target == '0)
      else $error("jump target set without a jump");

endmodule

bind rtype_alu_with_register_file rfalu_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_write_enable (rsp_write_enable),
   .rsp_write_index  (rsp_write_index),
   .rsp_write_value  (rsp_write_value),
   .rsp_overflow     (rsp_overflow),
   .rsp_jump_taken   (rsp_jump_taken),
   .rsp_jump_target  (rsp_jump_target)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the R-type ALU with register file.
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 10;
   localparam int MAX_REPORTS     = 40;
   localparam int DW              = rfalu_pkg::DATA_WIDTH;
   localparam logic [rfalu_pkg::OPC_W-1:0] OPC_FIRST_UNUSED = rfalu_pkg::OPC_WRITE + 1'b1;
   localparam logic [rfalu_pkg::OPC_W-1:0] OPC_LAST_UNUSED  = {rfalu_pkg::OPC_W{1'b1}};

   typedef struct {
      logic                        we;
      logic [rfalu_pkg::IDX_W-1:0] widx;
      logic [rfalu_pkg::OUT_W-1:0] wval;
      logic                        ovf;
      logic                        jmp;
      logic [rfalu_pkg::OUT_W-1:0] target;
   } retire_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [rfalu_pkg::OPC_W-1:0] req_opcode;
   logic [rfalu_pkg::IDX_W-1:0] req_src_a_index;
   logic [rfalu_pkg::IDX_W-1:0] req_src_b_index;
   logic [rfalu_pkg::IDX_W-1:0] req_dest_index;
   logic [rfalu_pkg::IDX_W-1:0] req_shift_amount;
   logic [rfalu_pkg::OUT_W-1:0] req_load_value;
   logic rsp_valid;
   logic rsp_ready;
   logic rsp_write_enable;
   logic [rfalu_pkg::IDX_W-1:0] rsp_write_index;
   logic [rfalu_pkg::OUT_W-1:0] rsp_write_value;
   logic rsp_overflow;
   logic rsp_jump_taken;
   logic [rfalu_pkg::OUT_W-1:0] rsp_jump_target;

   rfalu_pkg::word_type shadow_regs [rfalu_pkg::NUM_REGS];
   retire_type expected_retire [$];
   int  mismatches = 0;
   int  cycle_count = 0;
   bit  sender_steady = 0;
   bit  receiver_steady = 0;
   bit  hold_request = 0;

   rtype_alu_with_register_file DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_src_a_index  (req_src_a_index),
      .req_src_b_index  (req_src_b_index),
      .req_dest_index   (req_dest_index),
      .req_shift_amount (req_shift_amount),
      .req_load_value   (req_load_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_write_enable (rsp_write_enable),
      .rsp_write_index  (rsp_write_index),
      .rsp_write_value  (rsp_write_value),
      .rsp_overflow     (rsp_overflow),
      .rsp_jump_taken   (rsp_jump_taken),
      .rsp_jump_target  (rsp_jump_target)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // Mostly back-to-back, some short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [rfalu_pkg::OUT_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return {1'b1, {(rfalu_pkg::OUT_W-1){1'b0}}};
         3: return {1'b0, {(rfalu_pkg::OUT_W-1){1'b1}}};
         4: return 1;
         default: return $urandom;
      endcase
   endfunction

   function automatic rfalu_pkg::word_type read_shadow(logic [rfalu_pkg::IDX_W-1:0] idx);
      if (int'(idx) >= rfalu_pkg::NUM_REGS) return '0;
      return shadow_regs[idx];
   endfunction

   // Execute one instruction on the shadow file and return what should retire.
   function automatic retire_type execute_instr(logic [rfalu_pkg::OPC_W-1:0] opc,
                                                logic [rfalu_pkg::IDX_W-1:0] ia,
                                                logic [rfalu_pkg::IDX_W-1:0] ib,
                                                logic [rfalu_pkg::IDX_W-1:0] id,
                                                logic [rfalu_pkg::IDX_W-1:0] sh,
                                                logic [rfalu_pkg::OUT_W-1:0] load);
      retire_type res;
      rfalu_pkg::word_type a, b, r;
      logic signed [DW-1:0] b_signed;
      logic wr;
      a = read_shadow(ia);
      b = read_shadow(ib);
      b_signed = b;
      r = '0;
      wr = 1'b1;
      res.ovf = 1'b0;
      res.jmp = 1'b0;
      res.target = '0;
      case (opc)
         rfalu_pkg::OPC_ADD: begin
            r = a + b;
            res.ovf = (a[DW-1] == b[DW-1]) && (r[DW-1] != a[DW-1]);
         end
         rfalu_pkg::OPC_SUB: begin
            r = a - b;
            res.ovf = (a[DW-1] != b[DW-1]) && (r[DW-1] != a[DW-1]);
         end
         rfalu_pkg::OPC_AND:  r = a & b;
         rfalu_pkg::OPC_OR:   r = a | b;
         rfalu_pkg::OPC_XOR:  r = a ^ b;
         rfalu_pkg::OPC_NOR:  r = ~(a | b);
         rfalu_pkg::OPC_NAND: r = ~(a & b);
         rfalu_pkg::OPC_SLT:  r = ($signed(a) < $signed(b)) ? rfalu_pkg::word_type'(1) : '0;
         rfalu_pkg::OPC_SLL:  r = (int'(sh) >= DW) ? '0 : b << sh;
         rfalu_pkg::OPC_SRL:  r = (int'(sh) >= DW) ? '0 : b >> sh;
         rfalu_pkg::OPC_SRA: begin
            if (int'(sh) >= DW) r = {DW{b[DW-1]}};
            else r = b_signed >>> sh;
         end
         rfalu_pkg::OPC_JR: begin
            wr = 1'b0;
            res.jmp = 1'b1;
            res.target = rfalu_pkg::OUT_W'(a);
         end
         rfalu_pkg::OPC_WRITE: r = DW'(load);
         default:   wr = 1'b0;
      endcase
      if (int'(id) >= rfalu_pkg::NUM_REGS) wr = 1'b0;
      if (wr) shadow_regs[id] = r;
      res.we   = wr;
      res.widx = wr ? id : '0;
      res.wval = wr ? rfalu_pkg::OUT_W'(r) : '0;
      return res;
   endfunction

   // Offer one beat, hold it until accepted, then record the expected retirement.
   task automatic send_instr(logic [rfalu_pkg::OPC_W-1:0] opc,
                             logic [rfalu_pkg::IDX_W-1:0] ia,
                             logic [rfalu_pkg::IDX_W-1:0] ib,
                             logic [rfalu_pkg::IDX_W-1:0] id,
                             logic [rfalu_pkg::IDX_W-1:0] sh,
                             logic [rfalu_pkg::OUT_W-1:0] load);
      int gap;
      gap = sender_steady ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= opc;
      req_src_a_index  <= ia;
      req_src_b_index  <= ib;
      req_dest_index   <= id;
      req_shift_amount <= sh;
      req_load_value   <= load;
      do @(posedge clock); while (!req_ready);
      expected_retire.push_back(execute_instr(opc, ia, ib, id, sh, load));
   endtask

   task automatic send_random_instr();
      logic [rfalu_pkg::OPC_W-1:0] opc;
      int r;
      r = $urandom_range(0, 99);
      if (r < 18) opc = rfalu_pkg::OPC_WRITE;
      else if (r < 21)
         opc = rfalu_pkg::OPC_W'($urandom_range(OPC_FIRST_UNUSED, OPC_LAST_UNUSED));
      else opc = rfalu_pkg::OPC_W'($urandom_range(rfalu_pkg::OPC_ADD, rfalu_pkg::OPC_JR));
      send_instr(opc, rfalu_pkg::IDX_W'($urandom), rfalu_pkg::IDX_W'($urandom),
                 rfalu_pkg::IDX_W'($urandom), rfalu_pkg::IDX_W'($urandom), pick_value());
   endtask

   task automatic lower_valid();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_retire.size() != 0) @(posedge clock);
   endtask

   function automatic void compare_field(string name, logic [rfalu_pkg::OUT_W-1:0] want,
                                         logic [rfalu_pkg::OUT_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      retire_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_retire.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response beat, expected none actual index %h value %h",
                     $time, rsp_write_index, rsp_write_value);
         end else begin
            want = expected_retire.pop_front();
            compare_field("write_enable", rfalu_pkg::OUT_W'(want.we),
                          rfalu_pkg::OUT_W'(rsp_write_enable));
            compare_field("write_index", rfalu_pkg::OUT_W'(want.widx),
                          rfalu_pkg::OUT_W'(rsp_write_index));
            compare_field("write_value", want.wval, rsp_write_value);
            compare_field("overflow", rfalu_pkg::OUT_W'(want.ovf),
                          rfalu_pkg::OUT_W'(rsp_overflow));
            compare_field("jump_taken", rfalu_pkg::OUT_W'(want.jmp),
                          rfalu_pkg::OUT_W'(rsp_jump_taken));
            compare_field("jump_target", want.target, rsp_jump_target);
         end
      end
   end

   initial begin : receiver
      int stall;
      int hold_left;
      stall = 0;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = RSP_HOLD_CYCLES;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (receiver_steady) begin
            rsp_ready <= 1'b1;
         end else if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   task automatic test_directed_cases();
      send_instr(rfalu_pkg::OPC_WRITE, 0, 0, 1, 0, 32'h7FFF_FFFF);
      send_instr(rfalu_pkg::OPC_WRITE, 0, 0, 2, 0, 32'h0000_0001);
      send_instr(rfalu_pkg::OPC_WRITE, 0, 0, 3, 0, 32'h8000_0000);
      send_instr(rfalu_pkg::OPC_WRITE, 0, 0, 4, 0, 32'hFFFF_FFFF);
      send_instr(rfalu_pkg::OPC_WRITE, 0, 0, 0, 0, 32'hA5A5_A5A5);   // register zero holds data
      send_instr(rfalu_pkg::OPC_WRITE, 0, 0, 31, 31, 32'h1234_5678);
      send_instr(rfalu_pkg::OPC_ADD, 1, 2, 5, 0, 0);                   // positive overflow
      send_instr(rfalu_pkg::OPC_SUB, 3, 2, 6, 0, 0);                   // negative overflow
      send_instr(rfalu_pkg::OPC_ADD, 4, 4, 7, 0, 0);                   // wraps, no overflow
      send_instr(rfalu_pkg::OPC_SUB, 2, 4, 8, 0, 0);
      send_instr(rfalu_pkg::OPC_AND, 4, 0, 9, 0, 0);
      send_instr(rfalu_pkg::OPC_OR, 3, 0, 10, 0, 0);
      send_instr(rfalu_pkg::OPC_XOR, 4, 0, 11, 0, 0);
      send_instr(rfalu_pkg::OPC_NOR, 0, 0, 12, 0, 0);
      send_instr(rfalu_pkg::OPC_NAND, 4, 4, 13, 0, 0);
      send_instr(rfalu_pkg::OPC_SLT, 3, 2, 14, 0, 0);   // signed: negative below positive
      send_instr(rfalu_pkg::OPC_SLT, 2, 3, 15, 0, 0);
      send_instr(rfalu_pkg::OPC_SLL, 0, 4, 16, 31, 0);
      send_instr(rfalu_pkg::OPC_SRL, 0, 3, 17, 31, 0);
      send_instr(rfalu_pkg::OPC_SRA, 0, 3, 18, 31, 0);                 // sign fills the word
      send_instr(rfalu_pkg::OPC_SRA, 0, 1, 19, 0, 0);
      send_instr(rfalu_pkg::OPC_JR, 31, 0, 20, 0, 0);
      send_instr(OPC_FIRST_UNUSED, 4, 4, 21, 5, 32'hFFFF_FFFF);
      send_instr(OPC_LAST_UNUSED, 4, 4, 22, 5, 32'hFFFF_FFFF);
      send_instr(rfalu_pkg::OPC_JR, 0, 0, 0, 0, 0);
   endtask

   task automatic test_back_to_back();
      sender_steady = 1;
      receiver_steady = 1;
      repeat (120) send_random_instr();
      sender_steady = 0;
      receiver_steady = 0;
   endtask

   task automatic test_output_backpressure();
      hold_request = 1;
      sender_steady = 1;
      repeat (40) send_random_instr();
      sender_steady = 0;
   endtask

   task automatic test_sender_pause();
      repeat (30) send_random_instr();
      lower_valid();
      wait_drained();
      repeat (30) send_random_instr();
   endtask

   // Operand loads followed by an op on them, mixed with free-running noise.
   task automatic test_random_mix();
      int sent;
      logic [rfalu_pkg::IDX_W-1:0] da, db;
      sent = 0;
      while (sent < 900) begin
         if ($urandom_range(0, 99) < 40) begin
            da = rfalu_pkg::IDX_W'($urandom);
            db = rfalu_pkg::IDX_W'($urandom);
            send_instr(rfalu_pkg::OPC_WRITE, rfalu_pkg::IDX_W'($urandom),
                       rfalu_pkg::IDX_W'($urandom), da, rfalu_pkg::IDX_W'($urandom),
                       pick_value());
            send_instr(rfalu_pkg::OPC_WRITE, rfalu_pkg::IDX_W'($urandom),
                       rfalu_pkg::IDX_W'($urandom), db, rfalu_pkg::IDX_W'($urandom),
                       pick_value());
            send_instr(rfalu_pkg::OPC_W'($urandom_range(rfalu_pkg::OPC_ADD, rfalu_pkg::OPC_JR)),
                       da, db, rfalu_pkg::IDX_W'($urandom), rfalu_pkg::IDX_W'($urandom),
                       $urandom);
            sent += 3;
         end else begin
            send_random_instr();
            sent++;
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = '0;
      req_src_a_index  = '0;
      req_src_b_index  = '0;
      req_dest_index   = '0;
      req_shift_amount = '0;
      req_load_value   = '0;
      foreach (shadow_regs[i]) shadow_regs[i] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_back_to_back();
      test_output_backpressure();
      test_sender_pause();
      test_random_mix();
      lower_valid();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_retire.size() == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
